>>> rtl/core/dps_pkg.sv
package dps_pkg;

	// default sizing
	localparam int DPS_ENTRIES   = 16;
	localparam int DPS_TIME_BITS = 32;

	// fixed field widths
	localparam int INTERVAL_W = 17;
	localparam int STAMP_W    = 32;
	localparam int STATUS_W   = 3;
	localparam int CMD_W      = 2;

	localparam logic [INTERVAL_W-1:0] MAX_INTERVAL = INTERVAL_W'(86400);
	localparam logic [INTERVAL_W-1:0] MIN_WAIT_RST = INTERVAL_W'(1);

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD   = 2'd0,
		CMD_POLL  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_NOT_DUE = 3'd0,
		ST_SAME    = 3'd1,
		ST_CHANGED = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_FULL    = 3'd4,
		ST_ADDED   = 3'd5
	} status_t;

	// what every cell of the row does in a cycle
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_POP
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_INS,
		S_DONE
	} state_t;

endpackage

>>> rtl/core/deadline_poll_scheduler_top.sv
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_ready  cmd, now_time, interval, observed_stamp, observed_valid
// out      output     out_valid/out_ready status, entry_id, wait_secs, next_head, entry_count
// cfg      input      cfg_valid/cfg_ready cfg_data (min_wait)
//
// One item at a time: the result is loaded from S_EXEC through S_DONE after the input
// transfer, with S_INS between them for a poll that services the head (pop through the
// cell row, then sorted insert in one pass); a new input is taken only back in S_IDLE.
// Every cell compares its due time with the new entry in parallel, so an insert needs
// no search along the row, whatever ENTRIES is. arst_n clears the count,
// min_wait to 1 and all control; cell contents are not reset. A waiting result holds
// the commit of the next item until it is transferred; cfg_ready is always high.
module deadline_poll_scheduler_top #(
	parameter int ENTRIES   = dps_pkg::DPS_ENTRIES,
	parameter int TIME_BITS = dps_pkg::DPS_TIME_BITS,
	parameter int SLOT_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	parameter int CNT_W     = $clog2(ENTRIES + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [dps_pkg::CMD_W-1:0]      cmd,
	input  logic [TIME_BITS-1:0]           now_time,
	input  logic [dps_pkg::INTERVAL_W-1:0] interval,
	input  logic [dps_pkg::STAMP_W-1:0]    observed_stamp,
	input  logic                           observed_valid,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [dps_pkg::STATUS_W-1:0]   status,
	output logic [SLOT_W-1:0]              entry_id,
	output logic [dps_pkg::INTERVAL_W-1:0] wait_secs,
	output logic [SLOT_W-1:0]              next_head,
	output logic [CNT_W-1:0]               entry_count,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dps_pkg::INTERVAL_W-1:0] cfg_data
);
	import dps_pkg::*;

	localparam int DUE_W = TIME_BITS + 1;

	state_t state_q, state_d;

	// captured input item
	logic [CMD_W-1:0]      cmd_q;
	logic [TIME_BITS-1:0]  now_q;
	logic [INTERVAL_W-1:0] interval_q;
	logic [STAMP_W-1:0]    stamp_q;
	logic                  ovalid_q;

	logic [INTERVAL_W-1:0] min_wait_q;
	logic [CNT_W-1:0]      cnt_q, cnt_d;

	// serviced head waiting for re-insertion
	logic [SLOT_W-1:0]     ins_slot_q;
	logic [INTERVAL_W-1:0] ins_period_q;
	logic [DUE_W-1:0]      ins_due_q;
	logic [STAMP_W-1:0]    ins_stamp_q;
	status_t               ins_status_q;

	// result waiting for the post-step head
	status_t               pst_q, pst_d;
	logic [SLOT_W-1:0]     pid_q, pid_d;
	logic [INTERVAL_W-1:0] pwait_q, pwait_d;

	// output register
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [SLOT_W-1:0]     entry_id_q;
	logic [INTERVAL_W-1:0] wait_q;
	logic [SLOT_W-1:0]     next_head_q;
	logic [CNT_W-1:0]      entry_count_q;

	cell_ctl_t             ctl;
	logic                  accept_in, do_pop, do_commit, load_out, out_free, from_input;

	logic [SLOT_W-1:0]     new_slot, head_slot;
	logic [INTERVAL_W-1:0] new_period, head_period;
	logic [DUE_W-1:0]      new_due, head_due;
	logic [STAMP_W-1:0]    new_stamp, head_stamp;

	logic [DUE_W-1:0]      now_ext, diff;
	logic [INTERVAL_W-1:0] clamp_w, wait_nd;
	logic                  not_due, changed, interval_ok, full;
	logic [STAMP_W-1:0]    obs_stamp;

	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	// head arithmetic
	assign now_ext     = {1'b0, now_q};
	assign not_due     = now_ext < head_due;
	assign diff        = head_due - now_ext;
	assign clamp_w     = (diff > DUE_W'(MAX_INTERVAL)) ? MAX_INTERVAL : diff[INTERVAL_W-1:0];
	assign wait_nd     = (clamp_w < min_wait_q) ? min_wait_q : clamp_w;
	assign obs_stamp   = ovalid_q ? stamp_q : '0;
	assign changed     = ovalid_q && (head_stamp != stamp_q);
	assign interval_ok = (interval_q != '0) && (interval_q <= MAX_INTERVAL);
	assign full        = cnt_q == CNT_W'(ENTRIES);

	// pick the entry to insert: a new one, or the serviced head
	always_comb begin
		if (from_input) begin
			new_slot   = cnt_q[SLOT_W-1:0];
			new_period = interval_q;
			new_due    = DUE_W'(interval_q);
			new_stamp  = obs_stamp;
		end else begin
			new_slot   = ins_slot_q;
			new_period = ins_period_q;
			new_due    = ins_due_q;
			new_stamp  = ins_stamp_q;
		end
	end

	dps_chain #(
		.ENTRIES   (ENTRIES),
		.TIME_BITS (TIME_BITS),
		.SLOT_W    (SLOT_W),
		.CNT_W     (CNT_W)
	) u_chain (
		.clk         (clk),
		.ctl         (ctl),
		.cnt         (cnt_q),
		.ins_slot    (new_slot),
		.ins_period  (new_period),
		.ins_due     (new_due),
		.ins_stamp   (new_stamp),
		.head_slot   (head_slot),
		.head_period (head_period),
		.head_due    (head_due),
		.head_stamp  (head_stamp)
	);

	// sequence one item
	always_comb begin
		state_d    = state_q;
		ctl.op     = OP_HOLD;
		in_ready   = 1'b0;
		accept_in  = 1'b0;
		do_pop     = 1'b0;
		do_commit  = 1'b0;
		load_out   = 1'b0;
		from_input = 1'b1;
		cnt_d      = cnt_q;
		pst_d      = ST_NOT_DUE;
		pid_d      = '0;
		pwait_d    = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				accept_in = in_valid;
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if ((cmd_t'(cmd_q) == CMD_POLL) && (cnt_q != '0) && !not_due) begin
					ctl.op  = OP_POP;
					do_pop  = 1'b1;
					cnt_d   = cnt_q - CNT_W'(1);
					state_d = S_INS;
				end else if (out_free) begin
					do_commit = 1'b1;
					state_d   = S_DONE;
					unique case (cmd_t'(cmd_q))
						CMD_ADD: begin
							pst_d = ST_ADDED;
							if (interval_ok && full) begin
								pst_d = ST_FULL;
							end else if (interval_ok) begin
								ctl.op = OP_INSERT;
								cnt_d  = cnt_q + CNT_W'(1);
								pid_d  = cnt_q[SLOT_W-1:0];
							end
						end
						CMD_POLL: begin
							if (cnt_q == '0) begin
								pst_d   = ST_EMPTY;
								pwait_d = min_wait_q;
							end else begin
								pst_d   = ST_NOT_DUE;
								pwait_d = wait_nd;
							end
						end
						CMD_CLEAR: begin
							pst_d = ST_EMPTY;
							cnt_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			S_INS: begin
				from_input = 1'b0;
				if (out_free) begin
					ctl.op    = OP_INSERT;
					do_commit = 1'b1;
					cnt_d     = cnt_q + CNT_W'(1);
					pst_d     = ins_status_q;
					pid_d     = ins_slot_q;
					state_d   = S_DONE;
				end
			end
			S_DONE: begin
				load_out = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			min_wait_q  <= MIN_WAIT_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cfg_valid) begin
				min_wait_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept_in) begin
			cmd_q      <= cmd;
			now_q      <= now_time;
			interval_q <= interval;
			stamp_q    <= observed_stamp;
			ovalid_q   <= observed_valid;
		end
		if (do_pop) begin
			ins_slot_q   <= head_slot;
			ins_period_q <= head_period;
			ins_due_q    <= now_ext + DUE_W'(head_period);
			ins_stamp_q  <= obs_stamp;
			ins_status_q <= changed ? ST_CHANGED : ST_SAME;
		end
		if (do_commit) begin
			pst_q   <= pst_d;
			pid_q   <= pid_d;
			pwait_q <= pwait_d;
		end
		if (load_out) begin
			status_q      <= pst_q;
			entry_id_q    <= pid_q;
			wait_q        <= pwait_q;
			next_head_q   <= (cnt_q != '0) ? head_slot : '0;
			entry_count_q <= cnt_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_id    = entry_id_q;
	assign wait_secs   = wait_q;
	assign next_head   = next_head_q;
	assign entry_count = entry_count_q;

	// count never passes the table size
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ENTRIES))
		else $error("entry count above table size");

	// re-insertion only follows a pop
	a_ins_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS) |-> ($past(state_q) == S_EXEC || $past(state_q) == S_INS))
		else $error("insert state entered without a pop");

	// the output slot is free when a result is loaded
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> !out_valid_q)
		else $error("result loaded over a pending one");

	// a result appears only after a finished item
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result without a finished item");

	// a pending re-insertion always has a free cell
	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS) |-> (cnt_q < CNT_W'(ENTRIES)))
		else $error("re-insertion into a full row");

endmodule

>>> rtl/core/dps_cell.sv
module dps_cell #(
	parameter int SLOT_W    = 4,
	parameter int TIME_BITS = 32
) (
	input  logic                          clk,
	input  dps_pkg::cell_ctl_t            ctl,
	input  logic                          valid,
	input  logic [SLOT_W-1:0]             ins_slot,
	input  logic [dps_pkg::INTERVAL_W-1:0] ins_period,
	input  logic [TIME_BITS:0]            ins_due,
	input  logic [dps_pkg::STAMP_W-1:0]   ins_stamp,
	input  logic                          left_keep,
	input  logic [SLOT_W-1:0]             left_slot,
	input  logic [dps_pkg::INTERVAL_W-1:0] left_period,
	input  logic [TIME_BITS:0]            left_due,
	input  logic [dps_pkg::STAMP_W-1:0]   left_stamp,
	input  logic [SLOT_W-1:0]             right_slot,
	input  logic [dps_pkg::INTERVAL_W-1:0] right_period,
	input  logic [TIME_BITS:0]            right_due,
	input  logic [dps_pkg::STAMP_W-1:0]   right_stamp,
	output logic                          keep,
	output logic [SLOT_W-1:0]             slot,
	output logic [dps_pkg::INTERVAL_W-1:0] period,
	output logic [TIME_BITS:0]            due,
	output logic [dps_pkg::STAMP_W-1:0]   stamp
);
	import dps_pkg::*;

	logic [SLOT_W-1:0]     slot_q;
	logic [INTERVAL_W-1:0] period_q;
	logic [TIME_BITS:0]    due_q;
	logic [STAMP_W-1:0]    stamp_q;

	// an entry due no later than the new one stays put, so ties go behind
	assign keep = valid && (due_q <= ins_due);

	// insert: keep, take the new entry, or shift right; pop: shift left
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_HOLD: begin
			end
			OP_INSERT: begin
				if (keep) begin
				end else if (left_keep) begin
					slot_q   <= ins_slot;
					period_q <= ins_period;
					due_q    <= ins_due;
					stamp_q  <= ins_stamp;
				end else begin
					slot_q   <= left_slot;
					period_q <= left_period;
					due_q    <= left_due;
					stamp_q  <= left_stamp;
				end
			end
			OP_POP: begin
				slot_q   <= right_slot;
				period_q <= right_period;
				due_q    <= right_due;
				stamp_q  <= right_stamp;
			end
			default: begin
			end
		endcase
	end

	assign slot   = slot_q;
	assign period = period_q;
	assign due    = due_q;
	assign stamp  = stamp_q;

endmodule

>>> rtl/core/dps_chain.sv
module dps_chain #(
	parameter int ENTRIES   = 16,
	parameter int TIME_BITS = 32,
	parameter int SLOT_W    = 4,
	parameter int CNT_W     = 5
) (
	input  logic                           clk,
	input  dps_pkg::cell_ctl_t             ctl,
	input  logic [CNT_W-1:0]               cnt,
	input  logic [SLOT_W-1:0]              ins_slot,
	input  logic [dps_pkg::INTERVAL_W-1:0] ins_period,
	input  logic [TIME_BITS:0]             ins_due,
	input  logic [dps_pkg::STAMP_W-1:0]    ins_stamp,
	output logic [SLOT_W-1:0]              head_slot,
	output logic [dps_pkg::INTERVAL_W-1:0] head_period,
	output logic [TIME_BITS:0]             head_due,
	output logic [dps_pkg::STAMP_W-1:0]    head_stamp
);
	import dps_pkg::*;

	logic                  keep_a   [ENTRIES];
	logic [SLOT_W-1:0]     slot_a   [ENTRIES];
	logic [INTERVAL_W-1:0] period_a [ENTRIES];
	logic [TIME_BITS:0]    due_a    [ENTRIES];
	logic [STAMP_W-1:0]    stamp_a  [ENTRIES];

	// build the row; the first cell sees the new entry on its left,
	// the last cell sees itself on its right
	for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
		logic                  lk;
		logic [SLOT_W-1:0]     ls, rs;
		logic [INTERVAL_W-1:0] lp, rp;
		logic [TIME_BITS:0]    ld, rd;
		logic [STAMP_W-1:0]    lt, rt;
		logic                  vld;

		assign vld = CNT_W'(k) < cnt;

		if (k == 0) begin : g_first
			assign lk = 1'b1;
			assign ls = ins_slot;
			assign lp = ins_period;
			assign ld = ins_due;
			assign lt = ins_stamp;
		end else begin : g_mid
			assign lk = keep_a[k-1];
			assign ls = slot_a[k-1];
			assign lp = period_a[k-1];
			assign ld = due_a[k-1];
			assign lt = stamp_a[k-1];
		end

		if (k == ENTRIES - 1) begin : g_last
			assign rs = slot_a[k];
			assign rp = period_a[k];
			assign rd = due_a[k];
			assign rt = stamp_a[k];
		end else begin : g_inner
			assign rs = slot_a[k+1];
			assign rp = period_a[k+1];
			assign rd = due_a[k+1];
			assign rt = stamp_a[k+1];
		end

		dps_cell #(
			.SLOT_W    (SLOT_W),
			.TIME_BITS (TIME_BITS)
		) u_cell (
			.clk          (clk),
			.ctl          (ctl),
			.valid        (vld),
			.ins_slot     (ins_slot),
			.ins_period   (ins_period),
			.ins_due      (ins_due),
			.ins_stamp    (ins_stamp),
			.left_keep    (lk),
			.left_slot    (ls),
			.left_period  (lp),
			.left_due     (ld),
			.left_stamp   (lt),
			.right_slot   (rs),
			.right_period (rp),
			.right_due    (rd),
			.right_stamp  (rt),
			.keep         (keep_a[k]),
			.slot         (slot_a[k]),
			.period       (period_a[k]),
			.due          (due_a[k]),
			.stamp        (stamp_a[k])
		);
	end

	assign head_slot   = slot_a[0];
	assign head_period = period_a[0];
	assign head_due    = due_a[0];
	assign head_stamp  = stamp_a[0];

endmodule

>>> dv/dps_checker.sv
`timescale 1ns / 100ps

module dps_checker
	import dps_pkg::*;
#(
	parameter int SLOTS  = DPS_ENTRIES,
	parameter int TIME_W = DPS_TIME_BITS,
	parameter int SLOT_W = $clog2(DPS_ENTRIES),
	parameter int CNT_W  = $clog2(DPS_ENTRIES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [TIME_W-1:0]     now_time,
	input  logic [INTERVAL_W-1:0] interval,
	input  logic [STAMP_W-1:0]    observed_stamp,
	input  logic                  observed_valid,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [STATUS_W-1:0]   status,
	input  logic [SLOT_W-1:0]     entry_id,
	input  logic [INTERVAL_W-1:0] wait_secs,
	input  logic [SLOT_W-1:0]     next_head,
	input  logic [CNT_W-1:0]      entry_count,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [INTERVAL_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending,
	output int                    checked_count,
	output int                    service_count,
	output int                    full_count
);

	typedef struct {
		status_t               status;
		logic [SLOT_W-1:0]     entry_id;
		logic [INTERVAL_W-1:0] wait_secs;
		logic [SLOT_W-1:0]     next_head;
		logic [CNT_W-1:0]      entry_count;
	} sched_result_t;

	// shadow of the watch table
	logic [INTERVAL_W-1:0] period_q  [SLOTS];
	logic [TIME_W-1:0]     served_at [SLOTS];
	logic [STAMP_W-1:0]    stamp_q   [SLOTS];
	logic [SLOT_W-1:0]     order_q   [SLOTS];
	int unsigned           used;
	logic [INTERVAL_W-1:0] floor_wait;

	sched_result_t outstanding[$];

	// due time one bit wider than the clock, so it never wraps
	function automatic logic [TIME_W:0] due_at(int unsigned slot);
		return {1'b0, served_at[slot]} + (TIME_W + 1)'(period_q[slot]);
	endfunction

	// place slot among the first n order entries; equal due times go behind
	function automatic void insert_by_due(int unsigned slot, int unsigned n);
		logic [TIME_W:0] due;
		int unsigned     p;
		due = due_at(slot);
		p = 0;
		while (p < n && due_at(order_q[p]) <= due) p++;
		for (int unsigned k = n; k > p; k--) order_q[k] = order_q[k - 1];
		order_q[p] = SLOT_W'(slot);
	endfunction

	function automatic sched_result_t predict_command(
		logic [CMD_W-1:0]      op,
		logic [TIME_W-1:0]     now,
		logic [INTERVAL_W-1:0] ivl,
		logic [STAMP_W-1:0]    stamp,
		logic                  stamp_ok
	);
		sched_result_t     r;
		logic [TIME_W:0]   due;
		logic [TIME_W:0]   gap;
		logic [SLOT_W-1:0] head;
		r.status    = ST_NOT_DUE;
		r.entry_id  = '0;
		r.wait_secs = '0;
		case (op)
			CMD_ADD: begin
				r.status = ST_ADDED;
				if (ivl >= 1 && ivl <= MAX_INTERVAL) begin
					if (used >= SLOTS) begin
						r.status = ST_FULL;
						full_count++;
					end else begin
						period_q[used]  = ivl;
						served_at[used] = '0;
						stamp_q[used]   = stamp_ok ? stamp : '0;
						r.entry_id      = SLOT_W'(used);
						insert_by_due(used, used);
						used++;
					end
				end
			end
			CMD_POLL: begin
				if (used == 0) begin
					r.status    = ST_EMPTY;
					r.wait_secs = floor_wait;
				end else begin
					head = order_q[0];
					due  = due_at(head);
					if ({1'b0, now} < due) begin
						// saturate the wait first, then apply the floor
						gap = due - {1'b0, now};
						if (gap > MAX_INTERVAL) gap = (TIME_W + 1)'(MAX_INTERVAL);
						r.wait_secs = gap[INTERVAL_W-1:0];
						if (r.wait_secs < floor_wait) r.wait_secs = floor_wait;
					end else begin
						served_at[head] = now;
						if (!stamp_ok) begin
							stamp_q[head] = '0;
							r.status      = ST_SAME;
						end else begin
							r.status      = (stamp_q[head] != stamp) ? ST_CHANGED : ST_SAME;
							stamp_q[head] = stamp;
						end
						// pop the head, then re-insert it by its new due time
						for (int unsigned k = 1; k < used; k++) order_q[k - 1] = order_q[k];
						insert_by_due(head, used - 1);
						r.entry_id = head;
						service_count++;
					end
				end
			end
			CMD_CLEAR: begin
				used     = 0;
				r.status = ST_EMPTY;
			end
			default: begin
			end
		endcase
		r.next_head   = (used > 0) ? order_q[0] : '0;
		r.entry_count = CNT_W'(used);
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// track config, predict commands and compare results at each edge
	always @(posedge clk or negedge arst_n) begin : monitor
		sched_result_t want;
		if (!arst_n) begin
			used          = 0;
			floor_wait    = MIN_WAIT_RST;
			fail_count    = 0;
			checked_count = 0;
			service_count = 0;
			full_count    = 0;
			outstanding.delete();
		end else begin
			if (cfg_valid && cfg_ready) floor_wait = cfg_data;
			if (in_valid && in_ready)
				outstanding.push_back(predict_command(cmd, now_time, interval,
					observed_stamp, observed_valid));
			if (out_valid && out_ready) begin
				if (outstanding.size() == 0) begin
					$error("result transfer with no command outstanding");
					fail_count++;
				end else begin
					want = outstanding.pop_front();
					check_field("status", 32'(want.status), 32'(status));
					check_field("entry_id", 32'(want.entry_id), 32'(entry_id));
					check_field("wait_secs", 32'(want.wait_secs), 32'(wait_secs));
					check_field("next_head", 32'(want.next_head), 32'(next_head));
					check_field("entry_count", 32'(want.entry_count), 32'(entry_count));
					checked_count++;
				end
			end
		end
		pending = outstanding.size();
	end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
	import dps_pkg::*;

	localparam int SLOT_W       = $clog2(DPS_ENTRIES);
	localparam int CNT_W        = $clog2(DPS_ENTRIES + 1);
	localparam int IDLE_LIMIT   = 2000;
	localparam int PHASE_ITEMS  = 225;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [CMD_W-1:0]         cmd;
	logic [DPS_TIME_BITS-1:0] now_time;
	logic [INTERVAL_W-1:0]    interval;
	logic [STAMP_W-1:0]       observed_stamp;
	logic                     observed_valid;
	logic                     out_valid;
	logic                     out_ready;
	logic [STATUS_W-1:0]      status;
	logic [SLOT_W-1:0]        entry_id;
	logic [INTERVAL_W-1:0]    wait_secs;
	logic [SLOT_W-1:0]        next_head;
	logic [CNT_W-1:0]         entry_count;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [INTERVAL_W-1:0]    cfg_data;

	int fail_count;
	int pending;
	int checked_count;
	int service_count;
	int full_count;

	int                       items_sent = 0;
	int                       burst_left = 0;
	int                       idle_cycles = 0;
	int                       ready_run = 0;
	rx_pattern_t              rx_pattern = RX_OPEN;
	logic [DPS_TIME_BITS-1:0] sim_seconds = '0;

	deadline_poll_scheduler_top dut (.*);

	dps_checker u_check (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver: pick a new stall pattern whenever the current run ends
	always @(negedge clk) begin
		if (ready_run == 0) begin
			rx_pattern = rx_pattern_t'($urandom_range(0, 3));
			ready_run  = $urandom_range(10, 120);
		end
		ready_run--;
		case (rx_pattern)
			RX_OPEN:   out_ready = 1'b1;
			RX_COIN:   out_ready = 1'($urandom_range(0, 1));
			RX_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
			default:   out_ready = (ready_run % 3 == 0);
		endcase
	end

	// end the run when no channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("** deadline_poll_scheduler_top: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// drive one command; bursts of transfers with random gaps between them
	task automatic push_item(
		input logic [CMD_W-1:0]         c,
		input logic [DPS_TIME_BITS-1:0] t,
		input logic [INTERVAL_W-1:0]    ivl,
		input logic [STAMP_W-1:0]       st,
		input logic                     st_ok
	);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		in_valid       = 1'b1;
		cmd            = c;
		now_time       = t;
		interval       = ivl;
		observed_stamp = st;
		observed_valid = st_ok;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		burst_left--;
		items_sent++;
	endtask

	// hold off until every result is back, then let the block settle
	task automatic drain_results();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_min_wait(input logic [INTERVAL_W-1:0] value);
		cfg_valid = 1'b1;
		cfg_data  = value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// small pool so repeated stamps show up often
	function automatic logic [STAMP_W-1:0] pick_stamp();
		return ($urandom_range(0, 3) == 0) ? STAMP_W'($urandom()) : STAMP_W'($urandom_range(0, 3));
	endfunction

	// clear, then fill to capacity or past it with short periods
	task automatic refill_table();
		push_item(CMD_CLEAR, STAMP_W'($urandom()), INTERVAL_W'($urandom()), $urandom(), 1'b1);
		repeat ($urandom_range(16, 19))
			push_item(CMD_ADD, $urandom(), INTERVAL_W'($urandom_range(1, 8)), pick_stamp(),
				$urandom_range(0, 7) != 0);
	endtask

	task automatic random_command();
		int                    roll;
		logic [INTERVAL_W-1:0] ivl;
		roll = $urandom_range(0, 99);
		if (roll < 2) begin
			push_item(CMD_UNUSED, $urandom(), INTERVAL_W'($urandom()), $urandom(),
				1'($urandom()));
		end else if (roll < 4) begin
			push_item(CMD_CLEAR, $urandom(), INTERVAL_W'($urandom()), $urandom(),
				1'($urandom()));
		end else if (roll < 32) begin
			// mostly short periods so entries come due often
			case ($urandom_range(0, 19))
				0:       ivl = '0;
				1:       ivl = INTERVAL_W'($urandom_range(86401, 131071));
				2:       ivl = MAX_INTERVAL;
				3, 4:    ivl = INTERVAL_W'($urandom_range(1, 86400));
				default: ivl = INTERVAL_W'($urandom_range(1, 24));
			endcase
			push_item(CMD_ADD, $urandom(), ivl, pick_stamp(), $urandom_range(0, 7) != 0);
		end else begin
			// advance the clock slowly, with rare jumps and wraps
			case ($urandom_range(0, 49))
				0:       sim_seconds = $urandom();
				1:       sim_seconds = 32'hFFFF_FFFF - $urandom_range(0, 40);
				2, 3:    sim_seconds += $urandom_range(0, 100000);
				default: sim_seconds += $urandom_range(0, 6);
			endcase
			push_item(CMD_POLL, sim_seconds, INTERVAL_W'($urandom()), pick_stamp(),
				$urandom_range(0, 7) != 0);
		end
	endtask

	task automatic random_phase();
		int target;
		target = items_sent + PHASE_ITEMS;
		refill_table();
		while (items_sent < target) begin
			if ($urandom_range(0, 59) == 0) refill_table();
			else random_command();
		end
	endtask

	initial begin
		logic [INTERVAL_W-1:0] floors [5];
		floors         = '{17'd0, '1, MAX_INTERVAL, 17'd3, 17'd0};
		floors[4]      = INTERVAL_W'($urandom_range(1, 86400));
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		cmd            = CMD_ADD;
		now_time       = '0;
		interval       = '0;
		observed_stamp = '0;
		observed_valid = 1'b0;
		out_ready      = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty table, odd commands, rejected periods
		push_item(CMD_POLL, '0, '0, '0, 1'b0);
		push_item(CMD_CLEAR, '0, '0, '0, 1'b0);
		push_item(CMD_UNUSED, '1, '1, '1, 1'b1);
		push_item(CMD_ADD, '0, '0, 32'd1, 1'b1);
		push_item(CMD_ADD, '0, MAX_INTERVAL + INTERVAL_W'(1), 32'd1, 1'b1);
		push_item(CMD_ADD, '0, '1, '1, 1'b1);
		// fill a few slots; the stamp of a missing object is dropped
		push_item(CMD_ADD, '0, 17'd1, '1, 1'b1);
		push_item(CMD_ADD, '0, MAX_INTERVAL, 32'h5A5A_5A5A, 1'b0);
		push_item(CMD_ADD, '0, 17'd5, 32'd7, 1'b1);
		push_item(CMD_ADD, '0, 17'd5, 32'd8, 1'b1);
		// not due, same stamp, changed stamp, missing object
		push_item(CMD_POLL, 32'd0, '0, '0, 1'b1);
		push_item(CMD_POLL, 32'd1, '0, '1, 1'b1);
		push_item(CMD_POLL, 32'd3, '0, '0, 1'b1);
		push_item(CMD_POLL, 32'd4, '0, 32'h1234, 1'b0);
		// service at the top of the time range; due time goes past it
		push_item(CMD_POLL, '1, '0, 32'hAAAA_5555, 1'b1);
		push_item(CMD_POLL, 32'd0, '0, '0, 1'b1);
		// full-period wait, a service near the top of the range, then a wait that saturates
		push_item(CMD_CLEAR, '0, '0, '0, 1'b0);
		push_item(CMD_ADD, '0, MAX_INTERVAL, 32'd1, 1'b1);
		push_item(CMD_POLL, '0, '0, 32'd1, 1'b1);
		push_item(CMD_POLL, 32'hFFFF_FF00, '0, 32'd1, 1'b1);
		push_item(CMD_POLL, 32'h5555_AAAA, '0, 32'd1, 1'b1);
		push_item(CMD_CLEAR, '0, '0, '0, 1'b0);

		// random traffic under the reset floor, then under each written floor
		random_phase();
		foreach (floors[i]) begin
			drain_results();
			write_min_wait(floors[i]);
			random_phase();
		end
		drain_results();

		$display("Sent %0d commands under six min_wait settings; %0d results checked.",
			items_sent, checked_count);
		$display("Saw %0d head services and %0d adds refused on a full table.",
			service_count, full_count);
		if (fail_count == 0 && pending == 0) begin
			$display("** deadline_poll_scheduler_top: PASSED **");
		end else begin
			$display("** deadline_poll_scheduler_top: FAILED **");
		end
		$finish;
	end

endmodule
